### hdl/nfba_pkg.sv
// Shared types and constants for the next-fit block bitmap allocator.
package nfba_pkg;

   localparam int MAX_BLOCKS   = 4096;
   localparam int BLK_W        = 12;
   localparam int CSR_W        = 13;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 16;

   localparam logic [CSR_W-1:0] CSR_RESET = 13'd4096;

   typedef enum logic [1:0] {
      OP_FIND    = 2'd0,
      OP_MARK    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_TEST    = 2'd3
   } op_type;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_REM   = 6'b000100,
      S_SCAN  = 6'b001000,
      S_RMW   = 6'b010000,
      S_POST  = 6'b100000
   } state_type;

   // first member lands in the highest bits: found is bit 0
   typedef struct packed {
      logic             range_error;
      logic             bit_used;
      logic [BLK_W-1:0] free_block;
      logic             found;
   } rsp_type;

endpackage

### hdl/nfba_ram.sv
// Generic simple dual-port RAM with registered read.
module nfba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/nfba_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
module nfba_rem #(
   parameter int DVD_W = 12,
   parameter int DVS_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVS_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         dvs_in  = divisor;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, dvs_ff}) ? DVS_W'(diff) : DVS_W'(trial);
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### hdl/next_fit_block_bitmap_allocator.sv
// Next-fit block allocator: used/free bitmap in RAM, rotating search start.
//
// Request word: req_tuser = opcode (find, mark, release, test), req_tdata =
// block number. One response word per request on rsp_*. Find scans the
// bitmap one 32-bit RAM row per cycle (pipelined reads), starting at the
// search start and wrapping at the last row in use; it reports the first
// free block and moves the search start past it without marking it.
// Mark/release read, modify and write back one row; test only reads it.
// Path to rsp_tvalid: mark/release/test pass through the RMW and post states;
// a range error or a find with no blocks in use goes straight to post; find
// checks up to rows_in_use + 1 rows (rows_in_use = ceil(count/32), 128 at the
// default size), fewer when a free block turns up early, after the remainder
// unit reduces the search start modulo the count if the count is at or below it.
// One request is in work at a time; a finished response sits in the output
// register, and the next request is accepted while it waits. A stalled receiver
// holds the following response in the post state, with req_tready low.
// Reset: the count register returns to 4096, the search start to 0, and a
// clearing pass writes every RAM row to zero (MAX_BLOCKS/32 rows, 128 by
// default) with req_tready low. csr_we may be written at any idle time.
module next_fit_block_bitmap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] block_number
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] found, [12:1] free_block, [13] bit_used,
                                    // [14] range_error
   input  logic        csr_we,
   input  logic [12:0] csr_wdata
);

   localparam int CW     = $clog2(nfba_pkg::MAX_BLOCKS + 1);
   localparam int AW     = $clog2(nfba_pkg::MAX_BLOCKS);
   localparam int WW     = (nfba_pkg::MAX_BLOCKS >= 32) ? 32 : 8;
   localparam int LW     = $clog2(WW);
   localparam int NWORDS = (nfba_pkg::MAX_BLOCKS + WW - 1) / WW;
   localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int KW     = WAW + 1;
   localparam int CMPW   = (CW > nfba_pkg::CSR_W) ? CW : nfba_pkg::CSR_W;
   localparam int RSP_PAD = nfba_pkg::RSP_TDATA_W - $bits(nfba_pkg::rsp_type);

   nfba_pkg::state_type          state_ff, state_in;
   logic [nfba_pkg::CSR_W-1:0]   csr_ff;
   nfba_pkg::op_type             op_ff, op_in;
   logic [LW-1:0]                pos_ff, pos_in;
   logic [WAW-1:0]               word_ff, word_in;
   logic [AW-1:0]                nm1_ff, nm1_in;
   logic [WAW-1:0]               lastw_ff, lastw_in;
   logic [AW-1:0]                ss_ff, ss_in;
   logic [AW-1:0]                start_ff, start_in;
   logic [WAW-1:0]               issue_ff, issue_in;
   logic [WAW-1:0]               chk_ff, chk_in;
   logic                         chkv_ff, chkv_in;
   logic [KW-1:0]                cnt_ff, cnt_in;
   logic [WAW-1:0]               clr_ff, clr_in;
   nfba_pkg::rsp_type            res_ff, res_in;
   nfba_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [CMPW-1:0]              csr_ext;
   logic [CW-1:0]                n_cur;
   nfba_pkg::op_type             req_op;
   logic [AW-1:0]                blk_idx;
   logic                         blk_err;
   logic                         ss_big;
   logic                         accept;
   logic                         rem_start;
   logic                         rem_done;
   logic [CW-1:0]                rem_val;
   logic [AW-1:0]                rem_idx;

   logic                         ram_we;
   logic [WAW-1:0]               ram_waddr;
   logic [WW-1:0]                ram_wdata;
   logic [WAW-1:0]               ram_raddr;
   logic [WW-1:0]                ram_rdata;

   logic                         first_row;
   logic                         last_row;
   logic [WW-1:0]                row_mask;
   logic [WW-1:0]                row_free;
   logic                         hit;
   logic [LW-1:0]                hit_pos;
   logic [AW-1:0]                hit_idx;
   logic [WW-1:0]                row_mod;

   // count in use, clipped to the bitmap size
   assign csr_ext = CMPW'(csr_ff);
   assign n_cur   = (csr_ext > CMPW'(nfba_pkg::MAX_BLOCKS)) ? CW'(nfba_pkg::MAX_BLOCKS)
                                                             : CW'(csr_ext);

   assign req_op  = nfba_pkg::op_type'(req_tuser);
   assign blk_idx = AW'(req_tdata[nfba_pkg::BLK_W-1:0]);
   assign blk_err = CMPW'(req_tdata[nfba_pkg::BLK_W-1:0]) >= CMPW'(n_cur);
   assign ss_big  = CMPW'(ss_ff) >= CMPW'(n_cur);
   assign accept  = req_tvalid & req_tready;
   assign rem_idx = AW'(rem_val);

   assign req_tready = (state_ff == nfba_pkg::S_IDLE);

   nfba_rem #(
      .DVD_W (AW),
      .DVS_W (CW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (ss_ff),
      .divisor   (n_cur),
      .done      (rem_done),
      .remainder (rem_val)
   );

   nfba_ram #(
      .WIDTH (WW),
      .DEPTH (NWORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // row check: keep bits at or after the start on the first row, and bits
   // below the count on the last row in use
   assign first_row = (cnt_ff == '0);
   assign last_row  = (chk_ff == lastw_ff);

   always_comb begin
      for (int i = 0; i < WW; i++) begin
         row_mask[i] = (!first_row || (LW'(i) >= start_ff[LW-1:0])) &&
                       (!last_row || (LW'(i) <= nm1_ff[LW-1:0]));
      end
   end

   assign row_free = ~ram_rdata & row_mask;

   always_comb begin
      hit     = 1'b0;
      hit_pos = '0;
      for (int i = WW - 1; i >= 0; i--) begin
         if (row_free[i]) begin
            hit     = 1'b1;
            hit_pos = LW'(i);
         end
      end
   end

   assign hit_idx = AW'({chk_ff, hit_pos});

   always_comb begin
      row_mod         = ram_rdata;
      row_mod[pos_ff] = (op_ff == nfba_pkg::OP_MARK);
   end

   assign ram_we    = (state_ff == nfba_pkg::S_CLEAR) ||
                      ((state_ff == nfba_pkg::S_RMW) &&
                       ((op_ff == nfba_pkg::OP_MARK) || (op_ff == nfba_pkg::OP_RELEASE)));
   assign ram_waddr = (state_ff == nfba_pkg::S_CLEAR) ? clr_ff : word_ff;
   assign ram_wdata = (state_ff == nfba_pkg::S_CLEAR) ? '0 : row_mod;
   assign ram_raddr = (state_ff == nfba_pkg::S_IDLE) ? WAW'(blk_idx >> LW) : issue_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      nm1_in       = nm1_ff;
      lastw_in     = lastw_ff;
      ss_in        = ss_ff;
      start_in     = start_ff;
      issue_in     = issue_ff;
      chk_in       = chk_ff;
      chkv_in      = chkv_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rem_start    = 1'b0;

      unique case (state_ff)
         nfba_pkg::S_CLEAR: begin
            clr_in = WAW'(clr_ff + 1'b1);
            if (clr_ff == WAW'(NWORDS - 1)) begin
               state_in = nfba_pkg::S_IDLE;
            end
         end
         nfba_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               pos_in   = blk_idx[LW-1:0];
               word_in  = WAW'(blk_idx >> LW);
               nm1_in   = AW'(n_cur - 1'b1);
               lastw_in = WAW'(AW'(n_cur - 1'b1) >> LW);
               res_in   = '0;
               if (req_op == nfba_pkg::OP_FIND) begin
                  if (n_cur == '0) begin
                     state_in = nfba_pkg::S_POST;
                  end else if (ss_big) begin
                     rem_start = 1'b1;
                     state_in  = nfba_pkg::S_REM;
                  end else begin
                     start_in = ss_ff;
                     issue_in = WAW'(ss_ff >> LW);
                     cnt_in   = '0;
                     chkv_in  = 1'b0;
                     state_in = nfba_pkg::S_SCAN;
                  end
               end else if (blk_err) begin
                  res_in.range_error = 1'b1;
                  state_in           = nfba_pkg::S_POST;
               end else begin
                  state_in = nfba_pkg::S_RMW;
               end
            end
         end
         nfba_pkg::S_REM: begin
            if (rem_done) begin
               start_in = rem_idx;
               issue_in = WAW'(rem_idx >> LW);
               cnt_in   = '0;
               chkv_in  = 1'b0;
               state_in = nfba_pkg::S_SCAN;
            end
         end
         nfba_pkg::S_SCAN: begin
            // reads run one row ahead of the check
            issue_in = (issue_ff == lastw_ff) ? '0 : WAW'(issue_ff + 1'b1);
            chk_in   = issue_ff;
            chkv_in  = 1'b1;
            if (chkv_ff) begin
               if (hit) begin
                  res_in.found      = 1'b1;
                  res_in.free_block = nfba_pkg::BLK_W'(hit_idx);
                  ss_in             = (hit_idx == nm1_ff) ? '0 : AW'(hit_idx + 1'b1);
                  state_in          = nfba_pkg::S_POST;
               end else if (cnt_ff == KW'(lastw_ff) + KW'(1)) begin
                  // start row seen twice: map full
                  state_in = nfba_pkg::S_POST;
               end else begin
                  cnt_in = KW'(cnt_ff + 1'b1);
               end
            end
         end
         nfba_pkg::S_RMW: begin
            if (op_ff == nfba_pkg::OP_TEST) begin
               res_in.bit_used = ram_rdata[pos_ff];
            end
            state_in = nfba_pkg::S_POST;
         end
         nfba_pkg::S_POST: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = nfba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = nfba_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nfba_pkg::S_CLEAR;
         clr_ff       <= '0;
         ss_ff        <= '0;
         csr_ff       <= nfba_pkg::CSR_RESET;
         chkv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ss_ff        <= ss_in;
         chkv_ff      <= chkv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
      end
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      word_ff     <= word_in;
      nm1_ff      <= nm1_in;
      lastw_ff    <= lastw_in;
      start_ff    <= start_in;
      issue_ff    <= issue_in;
      chk_ff      <= chk_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_data_ff};

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while another is in work");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nfba_pkg::S_SCAN && chkv_ff) |-> (cnt_ff <= KW'(lastw_ff) + KW'(1)))
      else $error("scan ran past the start row");

   a_start_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nfba_pkg::S_POST && res_ff.found) |-> (ss_ff <= nm1_ff))
      else $error("search start left the blocks in use");

   a_found_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.found && rsp_data_ff.range_error))
      else $error("response both found and range error");

endmodule
